// ===== design/i2c_master_byte_engine_macros.svh =====
// ---------------------------------------------------------------------------
// i2c master byte engine assertion macros
// shared assertion forms for the engine rtl
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// checked only outside reset
`define I2CM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// i2c master engine package
// types, codes and helpers shared by the engine modules
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 16;
   localparam logic [2:0]  LAST_BIT   = 3'd7;
   localparam logic [3:0]  BITS_DONE  = 4'd7;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_HALF_PERIOD     = 1'b0,
      REG_STRETCH_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NACK    = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_START_SCL = 4'd1,
      PH_START_H1  = 4'd2,
      PH_START_H2  = 4'd3,
      PH_STOP_H1   = 4'd4,
      PH_STOP_SCL  = 4'd5,
      PH_STOP_H2   = 4'd6,
      PH_STOP_H3   = 4'd7,
      PH_W_H1      = 4'd8,
      PH_W_SCL     = 4'd9,
      PH_W_H2      = 4'd10,
      PH_R_H1      = 4'd11,
      PH_R_SCL     = 4'd12,
      PH_R_H2      = 4'd13
   } phase_type;

   // one timing tick as taken from the request channel
   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] write_data;
      logic       send_ack;
      logic       scl_in;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic [15:0] half_period;
      logic [15:0] stretch_timeout;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  bit_index;
      logic [15:0] half_counter;
      logic [15:0] stretch_counter;
      logic [7:0]  shift_byte;
      logic        scl_low;
      logic        sda_low;
      status_type  last_status;
      logic        read_ack;
      logic        write_nack;
      logic [7:0]  read_data;
   } eng_state_type;

   // sda pull for a data bit of a write, released for the ack slot
   function automatic logic write_sda(input logic [7:0] data, input logic [3:0] idx);
      logic pull;
      pull = 1'b0;
      if (idx <= BITS_DONE) begin
         pull = ~data[LAST_BIT - idx[2:0]];
      end
      return pull;
   endfunction

endpackage

`default_nettype wire

// ===== design/i2cm_step.sv =====
// ---------------------------------------------------------------------------
// i2c master engine tick logic
// next engine state for one timing tick
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_step (
   input  var i2cm_pkg::eng_state_type st,
   input  var i2cm_pkg::tick_type      tick,
   input  var i2cm_pkg::cfg_type       cfg,
   output i2cm_pkg::eng_state_type     st_next,
   output logic                        done
);

   logic [15:0] hc_inc;
   logic [15:0] half_limit;
   logic        half_done;
   logic        scl_to;
   logic        scl_end;
   logic [15:0] sc_inc;
   logic [3:0]  bit_inc;

   // saturating half counter, zero half period acts as one tick
   assign hc_inc     = (st.half_counter != 16'hFFFF) ? st.half_counter + 16'd1 : st.half_counter;
   assign half_limit = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
   assign half_done  = hc_inc >= half_limit;

   assign scl_to  = !tick.scl_in && (st.stretch_counter >= cfg.stretch_timeout);
   assign scl_end = tick.scl_in || scl_to;
   assign sc_inc  = st.stretch_counter + 16'd1;
   assign bit_inc = st.bit_index + 4'd1;

   always_comb begin
      st_next = st;
      done    = 1'b0;
      case (st.phase)
         i2cm_pkg::PH_IDLE: begin
            case (tick.operation)
               i2cm_pkg::OP_START: begin
                  st_next.sda_low         = 1'b0;
                  st_next.scl_low         = 1'b0;
                  st_next.stretch_counter = '0;
                  st_next.phase           = i2cm_pkg::PH_START_SCL;
               end
               i2cm_pkg::OP_STOP: begin
                  st_next.sda_low      = 1'b1;
                  st_next.half_counter = '0;
                  st_next.phase        = i2cm_pkg::PH_STOP_H1;
               end
               i2cm_pkg::OP_WRITE: begin
                  st_next.shift_byte   = tick.write_data;
                  st_next.bit_index    = '0;
                  st_next.write_nack   = 1'b0;
                  st_next.sda_low      = i2cm_pkg::write_sda(tick.write_data, 4'd0);
                  st_next.half_counter = '0;
                  st_next.phase        = i2cm_pkg::PH_W_H1;
               end
               i2cm_pkg::OP_READ: begin
                  st_next.sda_low      = 1'b0;
                  st_next.shift_byte   = '0;
                  st_next.bit_index    = '0;
                  st_next.read_ack     = tick.send_ack;
                  st_next.half_counter = '0;
                  st_next.phase        = i2cm_pkg::PH_R_H1;
               end
               default: ;
            endcase
         end
         i2cm_pkg::PH_START_SCL, i2cm_pkg::PH_STOP_SCL: begin
            // stretch timeout is ignored here, the sequence goes on
            if (scl_end) begin
               st_next.half_counter = '0;
               st_next.phase = (st.phase == i2cm_pkg::PH_START_SCL) ?
                               i2cm_pkg::PH_START_H1 : i2cm_pkg::PH_STOP_H2;
            end else begin
               st_next.stretch_counter = sc_inc;
            end
         end
         i2cm_pkg::PH_START_H1: begin
            st_next.half_counter = hc_inc;
            if (half_done) begin
               st_next.sda_low      = 1'b1;
               st_next.half_counter = '0;
               st_next.phase        = i2cm_pkg::PH_START_H2;
            end
         end
         i2cm_pkg::PH_START_H2: begin
            st_next.half_counter = hc_inc;
            if (half_done) begin
               st_next.scl_low     = 1'b1;
               st_next.phase       = i2cm_pkg::PH_IDLE;
               st_next.last_status = i2cm_pkg::ST_OK;
               done                = 1'b1;
            end
         end
         i2cm_pkg::PH_STOP_H1, i2cm_pkg::PH_W_H1, i2cm_pkg::PH_R_H1: begin
            st_next.half_counter = hc_inc;
            if (half_done) begin
               st_next.scl_low         = 1'b0;
               st_next.stretch_counter = '0;
               case (st.phase)
                  i2cm_pkg::PH_STOP_H1: st_next.phase = i2cm_pkg::PH_STOP_SCL;
                  i2cm_pkg::PH_W_H1:    st_next.phase = i2cm_pkg::PH_W_SCL;
                  default:              st_next.phase = i2cm_pkg::PH_R_SCL;
               endcase
            end
         end
         i2cm_pkg::PH_STOP_H2: begin
            st_next.half_counter = hc_inc;
            if (half_done) begin
               st_next.sda_low      = 1'b0;
               st_next.half_counter = '0;
               st_next.phase        = i2cm_pkg::PH_STOP_H3;
            end
         end
         i2cm_pkg::PH_STOP_H3: begin
            st_next.half_counter = hc_inc;
            if (half_done) begin
               st_next.phase       = i2cm_pkg::PH_IDLE;
               st_next.last_status = i2cm_pkg::ST_OK;
               done                = 1'b1;
            end
         end
         i2cm_pkg::PH_W_SCL: begin
            if (tick.scl_in) begin
               // ack slot samples the slave's answer
               if (st.bit_index > i2cm_pkg::BITS_DONE) begin
                  st_next.write_nack = tick.sda_in;
               end
               st_next.half_counter = '0;
               st_next.phase        = i2cm_pkg::PH_W_H2;
            end else if (scl_to) begin
               st_next.scl_low     = 1'b1;
               st_next.phase       = i2cm_pkg::PH_IDLE;
               st_next.last_status = i2cm_pkg::ST_TIMEOUT;
               done                = 1'b1;
            end else begin
               st_next.stretch_counter = sc_inc;
            end
         end
         i2cm_pkg::PH_W_H2: begin
            st_next.half_counter = hc_inc;
            if (half_done) begin
               st_next.scl_low = 1'b1;
               if (st.bit_index > i2cm_pkg::BITS_DONE) begin
                  st_next.phase       = i2cm_pkg::PH_IDLE;
                  st_next.last_status = st.write_nack ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
                  done                = 1'b1;
               end else begin
                  st_next.bit_index    = bit_inc;
                  st_next.sda_low      = i2cm_pkg::write_sda(st.shift_byte, bit_inc);
                  st_next.half_counter = '0;
                  st_next.phase        = i2cm_pkg::PH_W_H1;
               end
            end
         end
         i2cm_pkg::PH_R_SCL: begin
            if (scl_end) begin
               if (st.bit_index <= i2cm_pkg::BITS_DONE) begin
                  st_next.shift_byte[i2cm_pkg::LAST_BIT - st.bit_index[2:0]] =
                     st.shift_byte[i2cm_pkg::LAST_BIT - st.bit_index[2:0]] | tick.sda_in;
               end
               st_next.half_counter = '0;
               st_next.phase        = i2cm_pkg::PH_R_H2;
            end else begin
               st_next.stretch_counter = sc_inc;
            end
         end
         i2cm_pkg::PH_R_H2: begin
            st_next.half_counter = hc_inc;
            if (half_done) begin
               st_next.scl_low = 1'b1;
               if (st.bit_index <= i2cm_pkg::BITS_DONE) begin
                  st_next.bit_index = bit_inc;
                  if (bit_inc > i2cm_pkg::BITS_DONE) begin
                     st_next.sda_low = st.read_ack;
                  end
                  st_next.half_counter = '0;
                  st_next.phase        = i2cm_pkg::PH_R_H1;
               end else begin
                  st_next.sda_low     = 1'b0;
                  st_next.read_data   = st.shift_byte;
                  st_next.phase       = i2cm_pkg::PH_IDLE;
                  st_next.last_status = i2cm_pkg::ST_OK;
                  done                = 1'b1;
               end
            end
         end
         default: begin
            st_next.phase = i2cm_pkg::PH_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/i2c_master_byte_engine.sv =====
// ---------------------------------------------------------------------------
// i2c master byte engine
// open-drain i2c master: start, stop, write byte and read byte commands,
// one timing tick per request word
// ---------------------------------------------------------------------------
//
// channel   direction  handshake              contents
// req_      in         tvalid/tready          one tick: pin samples, optional command
// rsp_      out        tvalid/tready          line drives, busy, done, status, read byte
// csr_      in         write enable, no wait  half period and stretch timeout
//
// one tick is taken every clock cycle while the response side keeps up
// a tick passes through the request register, then the tick logic into the response register
// the engine state advances only when a tick moves into the response register
// a stall on rsp_tready holds the response register, and the request register once it
// fills; req_tready drops only when both are full
// synchronous reset releases both lines, empties both registers and loads the
// register defaults (half period 5, stretch timeout 1000)
`default_nettype none

`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // write_data, send_ack, scl_in,
                                                           // sda_in, zero pad
   input  logic [2:0]                          req_tuser,  // operation
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // scl_drive_low, sda_drive_low,
                                                           // busy_res, done_res, status,
                                                           // read_data, zero pad
   // register writes
   input  logic                                csr_we,
   input  logic [i2cm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // register file
   i2cm_pkg::cfg_type       cfg_ff;

   // request register
   logic                    in_valid_ff;
   i2cm_pkg::tick_type      in_word_ff;

   // engine state and response register
   i2cm_pkg::eng_state_type st_ff;
   i2cm_pkg::eng_state_type st_in;
   logic                    step_done;
   logic                    rsp_valid_ff;
   logic [15:0]             rsp_data_ff;
   logic [15:0]             rsp_data_in;

   logic                    out_free;
   logic                    proc;

   // assertion helpers
   logic                    in_scl_wait;
   logic                    eng_idle;
   logic                    stretch_ok;

   // the response register frees when empty or being taken
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period     <= 16'd5;
         cfg_ff.stretch_timeout <= 16'd1000;
      end else if (csr_we) begin
         case (csr_addr)
            i2cm_pkg::REG_HALF_PERIOD:     cfg_ff.half_period     <= csr_wdata;
            i2cm_pkg::REG_STRETCH_TIMEOUT: cfg_ff.stretch_timeout <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request word, payload only
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff.operation  <= req_tuser;
         in_word_ff.write_data <= req_tdata[7:0];
         in_word_ff.send_ack   <= req_tdata[8];
         in_word_ff.scl_in     <= req_tdata[9];
         in_word_ff.sda_in     <= req_tdata[10];
      end
   end

   i2cm_step u_step (
      .st      (st_ff),
      .tick    (in_word_ff),
      .cfg     (cfg_ff),
      .st_next (st_in),
      .done    (step_done)
   );

   // response word packed from the state after the tick
   assign rsp_data_in = {2'b00,
                         st_in.read_data,
                         st_in.last_status,
                         step_done,
                         (st_in.phase != i2cm_pkg::PH_IDLE),
                         st_in.sda_low,
                         st_in.scl_low};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= '{phase: i2cm_pkg::PH_IDLE, last_status: i2cm_pkg::ST_OK,
                           default: '0};
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (proc) begin
            rsp_valid_ff <= 1'b1;
            st_ff        <= st_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign in_scl_wait = st_ff.phase inside {i2cm_pkg::PH_START_SCL, i2cm_pkg::PH_STOP_SCL,
                                            i2cm_pkg::PH_W_SCL, i2cm_pkg::PH_R_SCL};
   assign eng_idle    = (st_ff.phase == i2cm_pkg::PH_IDLE);
   assign stretch_ok  = (st_ff.stretch_counter <= cfg_ff.stretch_timeout);

   // reset empties the pipeline
   `I2CM_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid_ff && !in_valid_ff, "pipeline not empty")
   // a completing tick leaves the engine idle
   `I2CM_ASSERT(a_done_idle, proc && step_done |=> eng_idle, "done without idle")
   // bit counter stays within data bits plus ack slot
   `I2CM_ASSERT(a_bit_range, st_ff.bit_index <= 4'd8, "bit index out of range")
   // stretch counter never passes the timeout while waiting on scl
   `I2CM_ASSERT(a_stretch_bound, in_scl_wait |-> stretch_ok, "stretch counter past timeout")

endmodule

`default_nettype wire

// ===== bench/i2c_master_byte_engine_tb.sv =====
// ---------------------------------------------------------------------------
// i2c master byte engine testbench
// feeds timing ticks from a simple slave model into the engine, predicts the
// line drives, busy, done, status and read byte of every response word and
// compares them field by field, under random sender gaps and response stalls
// ---------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
   import i2cm_pkg::*;

   localparam int CLOCK_HALF    = 6;
   localparam int LIMIT_CYCLES  = 2_000_000;
   localparam int HOLD_CYCLES   = 64;
   localparam int RANDOM_TICKS  = 750;
   localparam int SETTLE_CYCLES = 4;
   localparam int MSB_POS       = 7;

   // outcome of one tick of an scl wait
   typedef enum logic [1:0] {
      SCL_WAITING,
      SCL_HIGH,
      SCL_TIMED_OUT
   } scl_wait_type;

   // response word fields, laid out as on rsp_tdata from the top bit down
   typedef struct packed {
      logic [7:0] read_data;
      status_type status;
      logic       done;
      logic       busy;
      logic       sda_low;
      logic       scl_low;
   } line_out_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // write_data, send_ack, scl_in, sda_in, zero pad
   logic [2:0]            req_tuser  = OP_NONE;   // operation
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;   // scl_drive_low, sda_drive_low, busy_res, done_res,
                                       // status, read_data, zero pad
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = REG_HALF_PERIOD;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted engine state and register copies
   logic [15:0] cfg_half    = 16'd5;
   logic [15:0] cfg_stretch = 16'd1000;
   phase_type   eng_phase   = PH_IDLE;
   logic [3:0]  eng_bit     = '0;
   logic [15:0] eng_half    = '0;
   logic [15:0] eng_stretch = '0;
   logic [7:0]  eng_shift   = '0;
   logic        eng_scl_low = 1'b0;
   logic        eng_sda_low = 1'b0;
   status_type  eng_status  = ST_OK;
   logic        eng_read_ack   = 1'b0;
   logic        eng_write_nack = 1'b0;
   logic [7:0]  eng_read_byte  = '0;
   logic        eng_done       = 1'b0;

   line_out_type pending_lines[$];   // predicted response words, oldest first

   int errors       = 0;
   int ticks_sent   = 0;
   int burst_left   = 0;
   bit gaps_on      = 1'b1;
   int hold_asked   = 0;
   int hold_granted = 0;
   int hold_left    = 0;
   logic [9:0] rx_cycle = '0;

   i2c_master_byte_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ------------------------------------------------------------------
   // engine prediction
   // ------------------------------------------------------------------
   function automatic void start_half(input phase_type next);
      eng_phase = next;
      eng_half  = '0;
   endfunction

   // releasing scl always opens a fresh stretch window
   function automatic void release_scl(input phase_type next);
      eng_scl_low = 1'b0;
      eng_stretch = '0;
      eng_phase   = next;
   endfunction

   function automatic void complete(input status_type st);
      eng_phase  = PH_IDLE;
      eng_status = st;
      eng_done   = 1'b1;
   endfunction

   // data bits pull sda for a zero; the ack slot leaves it released
   function automatic void drive_write_bit();
      if (eng_bit <= MSB_POS) begin
         eng_sda_low = ~eng_shift[MSB_POS - eng_bit[2:0]];
      end else begin
         eng_sda_low = 1'b0;
      end
      start_half(PH_W_H1);
   endfunction

   // zero half period counts as one tick, counter saturates
   function automatic logic half_elapsed();
      logic [15:0] span;
      span = (cfg_half == 16'd0) ? 16'd1 : cfg_half;
      if (eng_half != 16'hFFFF) begin
         eng_half++;
      end
      return eng_half >= span;
   endfunction

   function automatic scl_wait_type scl_check(input logic scl);
      if (scl) begin
         return SCL_HIGH;
      end
      if (eng_stretch >= cfg_stretch) begin
         return SCL_TIMED_OUT;
      end
      eng_stretch++;
      return SCL_WAITING;
   endfunction

   function automatic void step_engine(input tick_type t);
      scl_wait_type w;
      line_out_type o;
      eng_done = 1'b0;
      case (eng_phase)
         PH_IDLE: begin
            // commands are only taken here, codes above read count as none
            case (t.operation)
               OP_START: begin
                  eng_sda_low = 1'b0;
                  release_scl(PH_START_SCL);
               end
               OP_STOP: begin
                  eng_sda_low = 1'b1;
                  start_half(PH_STOP_H1);
               end
               OP_WRITE: begin
                  eng_shift      = t.write_data;
                  eng_bit        = '0;
                  eng_write_nack = 1'b0;
                  drive_write_bit();
               end
               OP_READ: begin
                  eng_sda_low  = 1'b0;
                  eng_shift    = '0;
                  eng_bit      = '0;
                  eng_read_ack = t.send_ack;
                  start_half(PH_R_H1);
               end
               default: ;
            endcase
         end
         // start and stop treat a stretch timeout as scl high
         PH_START_SCL: if (scl_check(t.scl_in) != SCL_WAITING) start_half(PH_START_H1);
         PH_START_H1: if (half_elapsed()) begin
            eng_sda_low = 1'b1;
            start_half(PH_START_H2);
         end
         PH_START_H2: if (half_elapsed()) begin
            eng_scl_low = 1'b1;
            complete(ST_OK);
         end
         PH_STOP_H1: if (half_elapsed()) release_scl(PH_STOP_SCL);
         PH_STOP_SCL: if (scl_check(t.scl_in) != SCL_WAITING) start_half(PH_STOP_H2);
         PH_STOP_H2: if (half_elapsed()) begin
            eng_sda_low = 1'b0;
            start_half(PH_STOP_H3);
         end
         PH_STOP_H3: if (half_elapsed()) complete(ST_OK);
         PH_W_H1: if (half_elapsed()) release_scl(PH_W_SCL);
         PH_W_SCL: begin
            // a write gives up on a stretch timeout and parks scl low
            w = scl_check(t.scl_in);
            if (w == SCL_TIMED_OUT) begin
               eng_scl_low = 1'b1;
               complete(ST_TIMEOUT);
            end else if (w == SCL_HIGH) begin
               if (eng_bit > MSB_POS) begin
                  eng_write_nack = t.sda_in;
               end
               start_half(PH_W_H2);
            end
         end
         PH_W_H2: if (half_elapsed()) begin
            eng_scl_low = 1'b1;
            if (eng_bit > MSB_POS) begin
               if (eng_write_nack) begin
                  complete(ST_NACK);
               end else begin
                  complete(ST_OK);
               end
            end else begin
               eng_bit++;
               drive_write_bit();
            end
         end
         PH_R_H1: if (half_elapsed()) release_scl(PH_R_SCL);
         // a read carries on after a stretch timeout
         PH_R_SCL: if (scl_check(t.scl_in) != SCL_WAITING) begin
            if (eng_bit <= MSB_POS && t.sda_in) begin
               eng_shift[MSB_POS - eng_bit[2:0]] = 1'b1;
            end
            start_half(PH_R_H2);
         end
         PH_R_H2: if (half_elapsed()) begin
            eng_scl_low = 1'b1;
            if (eng_bit <= MSB_POS) begin
               eng_bit++;
               if (eng_bit > MSB_POS) begin
                  eng_sda_low = eng_read_ack;
               end
               start_half(PH_R_H1);
            end else begin
               eng_sda_low   = 1'b0;
               eng_read_byte = eng_shift;
               complete(ST_OK);
            end
         end
         default: eng_phase = PH_IDLE;
      endcase
      o.scl_low   = eng_scl_low;
      o.sda_low   = eng_sda_low;
      o.busy      = (eng_phase != PH_IDLE);
      o.done      = eng_done;
      o.status    = eng_status;
      o.read_data = eng_read_byte;
      pending_lines.push_back(o);
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // one word per call, with bursts and gaps while gaps_on is set
   task automatic send_tick(input tick_type t);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, t.sda_in, t.scl_in, t.send_ack, t.write_data};
      req_tuser  <= t.operation;
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end
      step_engine(t);
      ticks_sent++;
   endtask

   // the slave sees our own pull-down; otherwise it may stretch the clock
   task automatic line_tick(input logic [2:0] op, input logic [7:0] data, input logic ack,
                            input int stretch_pct);
      tick_type t;
      t.operation  = op;
      t.write_data = data;
      t.send_ack   = ack;
      t.scl_in     = eng_scl_low ? 1'b0 : 1'($urandom_range(99) >= stretch_pct);
      t.sda_in     = eng_sda_low ? 1'b0 : 1'($urandom);
      if ($urandom_range(63) == 0) begin
         t.scl_in = ~t.scl_in;   // line noise
      end
      if ($urandom_range(63) == 0) begin
         t.sda_in = ~t.sda_in;
      end
      send_tick(t);
   endtask

   // issue a command and tick until the engine is idle again; some ticks in
   // between carry commands that a busy engine must ignore
   task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic ack,
                              input int stretch_pct);
      line_tick(op, data, ack, stretch_pct);
      while (eng_phase != PH_IDLE) begin
         line_tick(($urandom_range(7) == 0) ? 3'($urandom_range(7)) : OP_NONE,
                   8'($urandom), 1'($urandom), stretch_pct);
      end
   endtask

   // sender pauses until every predicted word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(input csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == REG_HALF_PERIOD) begin
         cfg_half = value;
      end else begin
         cfg_stretch = value;
      end
   endtask

   // registers only change with the engine idle and nothing in flight
   task automatic configure(input logic [15:0] half, input logic [15:0] stretch);
      wait_drained();
      set_reg(REG_HALF_PERIOD, half);
      set_reg(REG_STRETCH_TIMEOUT, stretch);
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------
   // stall pattern cycles through four modes; a requested hold overrides it
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_granted) begin
         hold_granted <= hold_asked;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_cycle[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(9) >= 3);
            2'd2: rsp_tready <= (rx_cycle[1:0] != 2'b11);
            default: rsp_tready <= (rx_cycle[4:3] != 2'b11);
         endcase
      end
      rx_cycle <= rx_cycle + 1'b1;
   end

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      line_out_type got;
      line_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = line_out_type'(rsp_tdata[13:0]);
         if (pending_lines.size() == 0) begin
            $display("%0t: response word with no tick outstanding, expected none, actual %h",
                     $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_lines.pop_front();
            check_field("scl_drive_low", want.scl_low, got.scl_low);
            check_field("sda_drive_low", want.sda_low, got.sda_low);
            check_field("busy_res", want.busy, got.busy);
            check_field("done_res", want.done, got.done);
            check_field("status", want.status, got.status);
            check_field("read_data", want.read_data, got.read_data);
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // reset register defaults, every command, unused codes and byte extremes
   task automatic test_directed_commands();
      line_tick(OP_NONE, 8'h00, 1'b0, 0);
      for (int k = 5; k < 8; k++) begin
         line_tick(3'(k), 8'hFF, 1'b1, 0);   // unused codes, ignored
      end
      run_command(OP_START, 8'h00, 1'b0, 0);
      run_command(OP_WRITE, 8'h00, 1'b0, 0);
      run_command(OP_WRITE, 8'hFF, 1'b1, 25);
      run_command(OP_WRITE, 8'h5A, 1'b0, 0);
      run_command(OP_READ, 8'h00, 1'b1, 0);
      run_command(OP_READ, 8'hFF, 1'b0, 25);
      run_command(OP_STOP, 8'h00, 1'b0, 0);
   endtask

   // zero half period, zero and maximum stretch timeout, full-scale registers
   task automatic test_timing_extremes();
      configure(16'd0, 16'd0);
      run_command(OP_START, 8'h00, 1'b0, 100);
      run_command(OP_WRITE, 8'hC3, 1'b0, 100);   // times out at the first clock
      run_command(OP_READ, 8'h00, 1'b1, 100);    // timeout ignored in a read
      run_command(OP_WRITE, 8'h81, 1'b0, 60);
      run_command(OP_STOP, 8'h00, 1'b0, 100);
      configure(16'd1, 16'hFFFF);
      run_command(OP_WRITE, 8'h96, 1'b0, 40);
      run_command(OP_READ, 8'h00, 1'b0, 40);
      // full-scale half period, engine left idle to keep the run short
      configure(16'hFFFF, 16'd3);
      repeat (4) line_tick(OP_NONE, 8'($urandom), 1'($urandom), 0);
   endtask

   // long response hold while the sender keeps streaming
   task automatic test_backpressure();
      configure(16'd2, 16'd1000);
      gaps_on = 1'b0;
      hold_asked++;
      run_command(OP_WRITE, 8'h3C, 1'b0, 10);
      run_command(OP_READ, 8'h00, 1'b1, 10);
      gaps_on = 1'b1;
      wait_drained();
   endtask

   // mostly well-formed transactions, some stray commands and noise
   task automatic test_random_traffic();
      int first;
      int txn;
      int nbytes;
      int sp;
      logic [15:0] half;
      logic [15:0] stretch;
      first = ticks_sent;
      txn   = 0;
      while (ticks_sent - first < RANDOM_TICKS) begin
         if (txn % 3 == 0) begin
            case ($urandom_range(9))
               0: half = 16'd0;
               1: half = 16'($urandom_range(24, 5));
               default: half = 16'($urandom_range(3, 1));
            endcase
            case ($urandom_range(3))
               0, 1: stretch = 16'($urandom_range(4));
               2: stretch = 16'd1000;
               default: stretch = 16'hFFFF;
            endcase
            configure(half, stretch);
         end
         sp = $urandom_range(30);
         if ($urandom_range(5) == 0) begin
            // stray command and idle noise outside a transaction
            run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom), $urandom_range(100));
            repeat ($urandom_range(5)) line_tick(3'($urandom_range(7, 5)), 8'($urandom),
                                                 1'($urandom), sp);
         end else begin
            run_command(OP_START, 8'($urandom), 1'($urandom), sp);
            nbytes = $urandom_range(3, 1);
            repeat (nbytes) begin
               if ($urandom_range(1)) begin
                  run_command(OP_WRITE, 8'($urandom), 1'($urandom), sp);
               end else begin
                  run_command(OP_READ, 8'($urandom), 1'($urandom), sp);
               end
            end
            run_command(OP_STOP, 8'($urandom), 1'($urandom), sp);
         end
         txn++;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_timing_extremes();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (errors == 0) begin
         $display("i2c_master_byte_engine_tb OK");
      end else begin
         $display("i2c_master_byte_engine_tb NOT OK");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #(LIMIT_CYCLES * 2 * CLOCK_HALF);
      $display("i2c_master_byte_engine_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/i2cm_pkg.sv
design/i2cm_step.sv
design/i2c_master_byte_engine.sv
bench/i2c_master_byte_engine_tb.sv
